// ===== rtl/ktl_pkg.sv =====
package ktl_pkg;

	// Input item fields
	localparam int FUNC_W        = 1;
	localparam int ENTRY_INDEX_W = 8;
	localparam int ENTRY_TIME_W  = 24;
	localparam int QUERY_TIME_W  = 32;
	localparam int IN_DATA_W     = 64;
	localparam int IN_USER_W     = 1;

	// Result item fields
	localparam int FRAME_W       = 8;
	localparam int WEIGHT_B_W    = 16;
	localparam int WEIGHT_A_W    = 17;
	localparam int CYCLE_W       = 31;
	localparam int OUT_DATA_W    = 80;

	// Configuration port
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 16;
	localparam int FRAME_COUNT_W = 9;
	localparam int MAX_CYCLE_W   = 16;

	localparam logic [CFG_INDEX_W-1:0]   REG_FRAME_COUNT   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0]   REG_MAX_CYCLE     = 2'd1;
	localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 9'd1;
	localparam logic [MAX_CYCLE_W-1:0]   MAX_CYCLE_RESET   = 16'd1;

	// Item kinds carried on tuser
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Weights
	localparam logic [WEIGHT_A_W-1:0] WEIGHT_ONE  = 17'h10000;
	localparam logic [WEIGHT_B_W-1:0] WEIGHT_FULL = 16'hFFFF;

	// Shared divider step counts
	localparam int                    DIV_CNT_W     = 5;
	localparam logic [DIV_CNT_W-1:0] DIV_CYC_STEPS = 5'd31;
	localparam logic [DIV_CNT_W-1:0] DIV_WT_STEPS  = 5'd16;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_LAST,
		S_DIV_CYC,
		S_CYC_CHK,
		S_SRCH,
		S_WT_CHK,
		S_DIV_WT,
		S_DONE
	} ktl_state_t;

	// Table read address source
	typedef enum logic [1:0] {
		RD_LAST,
		RD_FIRST,
		RD_SRCH
	} ktl_rd_t;

	// Result kinds
	typedef enum logic [2:0] {
		RES_SINGLE,
		RES_NONPOS,
		RES_LAST,
		RES_CLAMP,
		RES_PAIR_FULL,
		RES_PAIR_ZERO,
		RES_PAIR_DIV
	} ktl_res_t;

	typedef struct packed {
		logic     mem_wr;
		logic     cap_query;
		ktl_rd_t  rd_sel;
		logic     div_start_cyc;
		logic     div_start_wt;
		logic     div_step;
		logic     cap_cyc;
		logic     srch_step;
		logic     res_set;
		ktl_res_t res_kind;
	} ktl_cmd_t;

	typedef struct packed {
		logic single;
		logic nonpos;
		logic last_zero;
		logic div_done;
		logic clamp;
		logic srch_exit;
		logic not_found;
		logic wt_zero;
	} ktl_sts_t;

endpackage

// ===== rtl/ktl_ctrl.sv =====
module ktl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_func,
	output logic             in_ready,
	input  logic             out_free,
	output logic             out_push,
	input  ktl_pkg::ktl_sts_t sts,
	output ktl_pkg::ktl_cmd_t cmd
);
	import ktl_pkg::*;

	ktl_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		out_push      = 1'b0;
		cmd           = '0;
		cmd.rd_sel    = RD_LAST;
		cmd.res_kind  = RES_SINGLE;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_func == FUNC_LOAD) begin
						cmd.mem_wr = 1'b1;
					end else begin
						cmd.cap_query = 1'b1;
						state_d       = S_CHK;
					end
				end
			end
			S_CHK: begin
				if (sts.single) begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = RES_SINGLE;
					state_d      = S_DONE;
				end else if (sts.nonpos) begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = RES_NONPOS;
					state_d      = S_DONE;
				end else begin
					cmd.rd_sel = RD_LAST;
					state_d    = S_LAST;
				end
			end
			S_LAST: begin
				if (sts.last_zero) begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = RES_LAST;
					state_d      = S_DONE;
				end else begin
					cmd.div_start_cyc = 1'b1;
					state_d           = S_DIV_CYC;
				end
			end
			S_DIV_CYC: begin
				if (sts.div_done) begin
					state_d = S_CYC_CHK;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_CYC_CHK: begin
				if (sts.clamp) begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = RES_CLAMP;
					state_d      = S_DONE;
				end else begin
					cmd.cap_cyc = 1'b1;
					cmd.rd_sel  = RD_FIRST;
					state_d     = S_SRCH;
				end
			end
			S_SRCH: begin
				cmd.rd_sel    = RD_SRCH;
				cmd.srch_step = 1'b1;
				if (sts.srch_exit) begin
					state_d = S_WT_CHK;
				end
			end
			S_WT_CHK: begin
				if (sts.not_found) begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = RES_PAIR_FULL;
					state_d      = S_DONE;
				end else if (sts.wt_zero) begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = RES_PAIR_ZERO;
					state_d      = S_DONE;
				end else begin
					cmd.div_start_wt = 1'b1;
					state_d          = S_DIV_WT;
				end
			end
			S_DIV_WT: begin
				if (sts.div_done) begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = RES_PAIR_DIV;
					state_d      = S_DONE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/ktl_dp.sv =====
module ktl_dp #(
	parameter int MAX_FRAMES = 256,
	parameter int TIME_BITS  = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ktl_pkg::ktl_cmd_t                   cmd,
	output ktl_pkg::ktl_sts_t                   sts,
	input  logic [ktl_pkg::FRAME_COUNT_W-1:0]   frame_count,
	input  logic [ktl_pkg::MAX_CYCLE_W-1:0]     max_cycle_count,
	input  logic [ktl_pkg::ENTRY_INDEX_W-1:0]   entry_index,
	input  logic [ktl_pkg::ENTRY_TIME_W-1:0]    entry_time,
	input  logic [ktl_pkg::QUERY_TIME_W-1:0]    query_time,
	output logic [ktl_pkg::FRAME_W-1:0]         frame_a,
	output logic [ktl_pkg::FRAME_W-1:0]         frame_b,
	output logic [ktl_pkg::WEIGHT_B_W-1:0]      weight_b,
	output logic [ktl_pkg::CYCLE_W-1:0]         cycle_count
);
	import ktl_pkg::*;

	localparam int IDX_W   = $clog2(MAX_FRAMES);
	localparam int N_W     = $clog2(MAX_FRAMES + 1);
	localparam int TRIAL_W = TIME_BITS + 1;

	// Keyframe time table
	logic [TIME_BITS-1:0] mem [MAX_FRAMES];
	logic [TIME_BITS-1:0] rdata_q;
	logic [IDX_W-1:0]     raddr;
	logic [IDX_W-1:0]     waddr;
	logic                 wr_ok;

	logic signed [QUERY_TIME_W-1:0] qt_q;
	logic [N_W-1:0]                 n;
	logic [IDX_W-1:0]               n_m1;

	// Divider
	logic [TIME_BITS-1:0] rem_q;
	logic [TIME_BITS-1:0] dsr_q;
	logic [CYCLE_W-1:0]   dvd_q;
	logic [CYCLE_W-1:0]   quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TRIAL_W-1:0]   trial;
	logic [TRIAL_W-1:0]   diff;
	logic                 ge;

	// Search
	logic [TIME_BITS-1:0] t_q;
	logic [TIME_BITS-1:0] t2_q;
	logic [CYCLE_W-1:0]   cyc_q;
	logic [IDX_W-1:0]     cmp_idx_q;
	logic [IDX_W-1:0]     fa_q;
	logic [IDX_W-1:0]     fb_q;
	logic                 found_q;
	logic                 srch_hit;
	logic                 srch_exit;
	logic [MAX_CYCLE_W-1:0] max_m1;

	// Frames in use, clipped to table depth
	always_comb begin
		n = (32'(frame_count) > 32'(MAX_FRAMES)) ? N_W'(MAX_FRAMES) : N_W'(frame_count);
		n_m1 = IDX_W'(n - 1'b1);
		max_m1 = max_cycle_count - 1'b1;
	end

	assign wr_ok = 32'(entry_index) < 32'(MAX_FRAMES);
	assign waddr = IDX_W'(entry_index);

	// Search compare
	assign srch_hit  = t_q < rdata_q;
	assign srch_exit = srch_hit || (cmp_idx_q == n_m1);

	// Read address select
	always_comb begin
		case (cmd.rd_sel)
			RD_LAST:  raddr = n_m1;
			RD_FIRST: raddr = IDX_W'(1);
			RD_SRCH:  raddr = srch_exit ? (cmp_idx_q - 1'b1) : (cmp_idx_q + 1'b1);
			default:  raddr = n_m1;
		endcase
	end

	// Table write and registered read
	always_ff @(posedge clk) begin
		if (cmd.mem_wr && wr_ok) begin
			mem[waddr] <= TIME_BITS'(entry_time);
		end
		rdata_q <= mem[raddr];
	end

	// One restoring divide step
	always_comb begin
		trial = {rem_q, dvd_q[CYCLE_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = trial >= {1'b0, dsr_q};
	end

	// Divider step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start_cyc) begin
			cnt_q <= DIV_CYC_STEPS;
		end else if (cmd.div_start_wt) begin
			cnt_q <= DIV_WT_STEPS;
		end else if (cmd.div_step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Divider payload: time / last frame, then (t - t1) * 65536 / (t2 - t1)
	always_ff @(posedge clk) begin
		if (cmd.div_start_cyc) begin
			rem_q <= '0;
			dsr_q <= rdata_q;
			dvd_q <= qt_q[CYCLE_W-1:0];
			quo_q <= '0;
		end else if (cmd.div_start_wt) begin
			rem_q <= t_q - rdata_q;
			dsr_q <= t2_q - rdata_q;
			dvd_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
			dvd_q <= {dvd_q[CYCLE_W-2:0], 1'b0};
			quo_q <= {quo_q[CYCLE_W-2:0], ge};
		end
	end

	// Query capture and linear search
	always_ff @(posedge clk) begin
		if (cmd.cap_query) begin
			qt_q <= query_time;
		end
		if (cmd.cap_cyc) begin
			t_q       <= rem_q;
			cyc_q     <= quo_q;
			cmp_idx_q <= IDX_W'(1);
		end else if (cmd.srch_step) begin
			if (srch_exit) begin
				fa_q    <= cmp_idx_q - 1'b1;
				fb_q    <= cmp_idx_q;
				t2_q    <= rdata_q;
				found_q <= srch_hit;
			end else begin
				cmp_idx_q <= cmp_idx_q + 1'b1;
			end
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			case (cmd.res_kind)
				RES_SINGLE: begin
					frame_a     <= '0;
					frame_b     <= '0;
					weight_b    <= '0;
					cycle_count <= '0;
				end
				RES_NONPOS: begin
					frame_a     <= '0;
					frame_b     <= FRAME_W'(1);
					weight_b    <= '0;
					cycle_count <= '0;
				end
				RES_LAST: begin
					frame_a     <= FRAME_W'(n_m1);
					frame_b     <= FRAME_W'(n_m1);
					weight_b    <= '0;
					cycle_count <= '0;
				end
				RES_CLAMP: begin
					frame_a     <= FRAME_W'(n_m1);
					frame_b     <= FRAME_W'(n_m1);
					weight_b    <= '0;
					cycle_count <= CYCLE_W'(max_m1);
				end
				RES_PAIR_FULL: begin
					frame_a     <= FRAME_W'(fa_q);
					frame_b     <= FRAME_W'(fb_q);
					weight_b    <= WEIGHT_FULL;
					cycle_count <= cyc_q;
				end
				RES_PAIR_ZERO: begin
					frame_a     <= FRAME_W'(fa_q);
					frame_b     <= FRAME_W'(fb_q);
					weight_b    <= '0;
					cycle_count <= cyc_q;
				end
				RES_PAIR_DIV: begin
					frame_a     <= FRAME_W'(fa_q);
					frame_b     <= FRAME_W'(fb_q);
					weight_b    <= quo_q[WEIGHT_B_W-1:0];
					cycle_count <= cyc_q;
				end
				default: begin
					frame_a     <= '0;
					frame_b     <= '0;
					weight_b    <= '0;
					cycle_count <= '0;
				end
			endcase
		end
	end

	// Status to controller
	always_comb begin
		sts.single    = n <= N_W'(1);
		sts.nonpos    = qt_q[QUERY_TIME_W-1] || (qt_q == '0);
		sts.last_zero = rdata_q == '0;
		sts.div_done  = cnt_q == '0;
		sts.clamp     = (max_cycle_count != '0) && (quo_q >= CYCLE_W'(max_cycle_count));
		sts.srch_exit = srch_exit;
		sts.not_found = !found_q;
		sts.wt_zero   = (t2_q <= rdata_q) || (t_q < rdata_q);
	end

endmodule

// ===== rtl/keyframe_time_lookup_core.sv =====
// Channel   Direction  Handshake                        Payload
// s_axis    in         s_axis_tvalid / s_axis_tready    tdata: index, time, query; tuser: func
// m_axis    out        m_axis_tvalid / m_axis_tready    tdata: frames, weights, cycle count
// cfg       in         cfg_valid / cfg_ready            cfg_index, cfg_data
//
// A load item is written to the table as it is accepted; a query runs a 31-step
// shared divider for the loop count, a linear search reading one table entry per
// cycle, then a 16-step divide for the weight.
// Special cases (single frame, time <= 0, last time zero, clamp) skip the search and weight divide.
// arst_n clears control and configuration; table contents are undefined until loaded.
// A finished result waits in the output register while the next item is accepted;
// a query only stalls if the previous result has still not been taken.
module keyframe_time_lookup_core #(
	parameter int MAX_FRAMES = 256,
	parameter int TIME_BITS  = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// entry_index[7:0], entry_time[31:8], query_time[63:32]
	input  logic [ktl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// func[0]
	input  logic [ktl_pkg::IN_USER_W-1:0]      s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// frame_a[7:0], frame_b[15:8], weight_b[31:16], weight_a[48:32], cycle_count[79:49]
	output logic [ktl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ktl_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ktl_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ktl_pkg::*;

	ktl_cmd_t cmd;
	ktl_sts_t sts;

	logic [FRAME_COUNT_W-1:0] frame_count_q;
	logic [MAX_CYCLE_W-1:0]   max_cycle_q;

	logic                     out_free;
	logic                     out_push;
	logic                     m_valid_q;
	logic [OUT_DATA_W-1:0]    m_data_q;

	logic [FRAME_W-1:0]       res_fa;
	logic [FRAME_W-1:0]       res_fb;
	logic [WEIGHT_B_W-1:0]    res_wb;
	logic [WEIGHT_A_W-1:0]    res_wa;
	logic [CYCLE_W-1:0]       res_cyc;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RESET;
			max_cycle_q   <= MAX_CYCLE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_COUNT: frame_count_q <= cfg_data[FRAME_COUNT_W-1:0];
				REG_MAX_CYCLE:   max_cycle_q   <= cfg_data[MAX_CYCLE_W-1:0];
				default: ;
			endcase
		end
	end

	ktl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_func  (s_axis_tuser[0]),
		.in_ready (s_axis_tready),
		.out_free (out_free),
		.out_push (out_push),
		.sts      (sts),
		.cmd      (cmd)
	);

	ktl_dp #(
		.MAX_FRAMES (MAX_FRAMES),
		.TIME_BITS  (TIME_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.frame_count     (frame_count_q),
		.max_cycle_count (max_cycle_q),
		.entry_index     (s_axis_tdata[7:0]),
		.entry_time      (s_axis_tdata[31:8]),
		.query_time      (s_axis_tdata[63:32]),
		.frame_a         (res_fa),
		.frame_b         (res_fb),
		.weight_b        (res_wb),
		.cycle_count     (res_cyc)
	);

	// Complementary weight
	assign res_wa = WEIGHT_ONE - {1'b0, res_wb};

	// Output register
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_push) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_push) begin
			m_data_q <= {res_cyc, res_wa, res_wb, res_fb, res_fa};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
	// A query holds off further items until its result is produced
	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == FUNC_QUERY))
		|=> !s_axis_tready)
		else $error("input accepted while a query is in progress");

	// A new result appears only after the controller pushed one
	a_valid_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(out_push))
		else $error("output valid without a result push");

	// The two weights always sum to one
	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((18'(m_axis_tdata[48:32]) + 18'(m_axis_tdata[31:16]))
			== 18'(WEIGHT_ONE)))
		else $error("weight_a and weight_b do not sum to one");
`endif

endmodule

// ===== verif/ktl_lookup_checker.sv =====
module ktl_lookup_checker
	import ktl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	// entry_index[7:0], entry_time[31:8], query_time[63:32]
	input  logic [IN_DATA_W-1:0]   s_axis_tdata,
	// func[0]
	input  logic [IN_USER_W-1:0]   s_axis_tuser,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// frame_a[7:0], frame_b[15:8], weight_b[31:16], weight_a[48:32], cycle_count[79:49]
	input  logic [OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     waiting,
	output int                     checked
);

	localparam int TABLE_DEPTH = 256;
	localparam int MAX_REPORTS = 100;

	// Same bit order as m_axis_tdata, frame_a in the low byte
	typedef struct packed {
		logic [CYCLE_W-1:0]    cycle_count;
		logic [WEIGHT_A_W-1:0] weight_a;
		logic [WEIGHT_B_W-1:0] weight_b;
		logic [FRAME_W-1:0]    frame_b;
		logic [FRAME_W-1:0]    frame_a;
	} lookup_t;

	logic [ENTRY_TIME_W-1:0]  key_times [TABLE_DEPTH];
	logic [FRAME_COUNT_W-1:0] frames_in_use = FRAME_COUNT_RESET;
	logic [MAX_CYCLE_W-1:0]   loop_limit    = MAX_CYCLE_RESET;
	lookup_t                  expected_lookups [$];
	lookup_t                  want;
	lookup_t                  got;

	function automatic lookup_t pack_lookup(int unsigned fa, int unsigned fb,
		int unsigned wb, int unsigned loops);
		lookup_t r;
		r.frame_a     = fa[FRAME_W-1:0];
		r.frame_b     = fb[FRAME_W-1:0];
		r.weight_b    = wb[WEIGHT_B_W-1:0];
		r.weight_a    = WEIGHT_ONE - {1'b0, wb[WEIGHT_B_W-1:0]};
		r.cycle_count = loops[CYCLE_W-1:0];
		return r;
	endfunction

	// Frame pair, weight and loop count for one query time
	function automatic lookup_t predict_lookup(logic signed [QUERY_TIME_W-1:0] qt);
		int unsigned       n, last, uq, loops, t, f, t1, t2, wb, i;
		longint unsigned   num;
		bit                hit;
		n = (32'(frames_in_use) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(frames_in_use);
		if (n <= 1)
			return pack_lookup(0, 0, 0, 0);
		if (qt <= 0)
			return pack_lookup(0, 1, 0, 0);
		last = 32'(key_times[n - 1]);
		if (last == 0)
			return pack_lookup(n - 1, n - 1, 0, 0);
		uq    = qt;
		loops = uq / last;
		if (loop_limit != 0 && loops >= 32'(loop_limit))
			return pack_lookup(n - 1, n - 1, 0, 32'(loop_limit) - 1);
		t = uq % last;

		// lowest f with t below the next frame time
		hit = 1'b0;
		f   = n - 2;
		for (i = 0; i + 1 < n; i++) begin
			if (t < 32'(key_times[i + 1])) begin
				f   = i;
				hit = 1'b1;
				break;
			end
		end
		t1 = 32'(key_times[f]);
		t2 = 32'(key_times[f + 1]);
		if (!hit) begin
			wb = 32'(WEIGHT_FULL);
		end else if (t2 <= t1 || t < t1) begin
			wb = 0;
		end else begin
			num = longint'(t - t1) << 16;
			num = num / longint'(t2 - t1);
			wb  = (num > 64'(WEIGHT_FULL)) ? 32'(WEIGHT_FULL) : 32'(num);
		end
		return pack_lookup(f, f + 1, wb, loops);
	endfunction

	function automatic void compare_field(string field, longint unsigned exp_v,
		longint unsigned act_v);
		if (exp_v != act_v) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
		end
	endfunction

	// Track config and table, queue predictions, compare results in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use = FRAME_COUNT_RESET;
			loop_limit    = MAX_CYCLE_RESET;
			expected_lookups.delete();
			fail_count    = 0;
			checked       = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_COUNT: frames_in_use = cfg_data[FRAME_COUNT_W-1:0];
					REG_MAX_CYCLE:   loop_limit    = cfg_data[MAX_CYCLE_W-1:0];
					default: ;
				endcase
			end

			// result first: it can only belong to an earlier item
			if (m_axis_tvalid && m_axis_tready) begin
				got = lookup_t'(m_axis_tdata);
				checked++;
				if (expected_lookups.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: result %h with no lookup pending, expected none", $time,
							m_axis_tdata);
				end else begin
					want = expected_lookups.pop_front();
					compare_field("frame_a", 64'(want.frame_a), 64'(got.frame_a));
					compare_field("frame_b", 64'(want.frame_b), 64'(got.frame_b));
					compare_field("weight_b", 64'(want.weight_b), 64'(got.weight_b));
					compare_field("weight_a", 64'(want.weight_a), 64'(got.weight_a));
					compare_field("cycle_count", 64'(want.cycle_count),
						64'(got.cycle_count));
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser[0] == FUNC_QUERY)
					expected_lookups.push_back(
						predict_lookup(s_axis_tdata[IN_DATA_W-1 -: QUERY_TIME_W]));
				else
					key_times[s_axis_tdata[ENTRY_INDEX_W-1:0]] =
						s_axis_tdata[ENTRY_INDEX_W +: ENTRY_TIME_W];
			end
		end
		waiting = expected_lookups.size();
	end

endmodule

// ===== verif/tb_keyframe_time_lookup_core.sv =====
module tb_keyframe_time_lookup_core;
	import ktl_pkg::*;

	localparam int ITEM_TARGET    = 1950;
	localparam int HOLD_CYCLES    = 400;   // beyond the slowest query at 256 frames
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TABLE_DEPTH    = 256;
	localparam int unsigned TIME_MAX = 24'hFF_FFFF;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
	logic [IN_USER_W-1:0]   s_axis_tuser  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;

	int fail_count;
	int waiting;
	int checked;

	// stimulus-side copy of the table, used to aim query times and to repeat an earlier entry's time
	logic [ENTRY_TIME_W-1:0] shadow_times [TABLE_DEPTH];
	int unsigned cur_frames = 1;
	int unsigned cur_limit  = 1;
	bit          gaps_on    = 1'b1;
	int          loads_sent, queries_sent, phases_run;
	int          quiet_cycles = 0;

	keyframe_time_lookup_core dut (.*);

	ktl_lookup_checker u_checker (.*);

	always #10 clk = ~clk;

	// Result side backpressure
	always @(negedge clk)
		m_axis_tready <= !gaps_on || ($urandom_range(99) >= 30);

	// Watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Present one item at a falling edge and hold it until taken
	task automatic send_item(logic func, logic [ENTRY_INDEX_W-1:0] idx,
		logic [ENTRY_TIME_W-1:0] etime, logic [QUERY_TIME_W-1:0] qt);
		while (gaps_on && $urandom_range(99) < 30) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {qt, etime, idx};
		s_axis_tuser  <= func;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic load_entry(logic [ENTRY_INDEX_W-1:0] idx, logic [ENTRY_TIME_W-1:0] etime);
		shadow_times[idx] = etime;
		loads_sent++;
		send_item(FUNC_LOAD, idx, etime, $urandom);
	endtask

	task automatic query_at(logic [QUERY_TIME_W-1:0] qt);
		queries_sent++;
		send_item(FUNC_QUERY, ENTRY_INDEX_W'($urandom), ENTRY_TIME_W'($urandom), qt);
	endtask

	// Let every pending lookup come back, then give the block time to settle
	task automatic drain_and_hold();
		s_axis_tvalid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (HOLD_CYCLES) @(negedge clk);
	endtask

	// Both registers, plus one write to an unused index
	task automatic set_config(int unsigned n, int unsigned mc);
		logic [CFG_INDEX_W-1:0] idx_list [3];
		logic [CFG_DATA_W-1:0]  data_list [3];
		drain_and_hold();
		idx_list[0]  = REG_FRAME_COUNT;
		data_list[0] = CFG_DATA_W'(n);
		idx_list[1]  = REG_MAX_CYCLE;
		data_list[1] = CFG_DATA_W'(mc);
		idx_list[2]  = $urandom_range(1) ? REG_SPARE_A : REG_SPARE_B;
		data_list[2] = CFG_DATA_W'($urandom);
		cfg_valid <= 1'b1;
		for (int k = 0; k < 3; k++) begin
			cfg_index <= idx_list[k];
			cfg_data  <= data_list[k];
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid  <= 1'b0;
		cur_frames = n;
		cur_limit  = mc;
	endtask

	// Load entries 0..n-1: mostly increasing from 0, sometimes scrambled
	task automatic fill_table(int unsigned n);
		int unsigned step_max, t, pick;
		if ($urandom_range(99) < 75) begin
			step_max = (n > 1) ? TIME_MAX / (n - 1) : TIME_MAX;
			pick = $urandom_range(2);
			if (pick == 0 && step_max > 20)
				step_max = 20;
			else if (pick == 1 && step_max > 5000)
				step_max = 5000;
			t = 0;
			for (int unsigned i = 0; i < n; i++) begin
				load_entry(ENTRY_INDEX_W'(i), ENTRY_TIME_W'(t));
				t += $urandom_range(1, step_max);
			end
		end else begin
			for (int unsigned i = 0; i < n; i++) begin
				pick = $urandom_range(3);
				if (pick == 0)
					t = (i == 0) ? 0 : 32'(shadow_times[i - 1]);
				else if (pick == 1)
					t = $urandom_range(0, 100);
				else
					t = $urandom & TIME_MAX;
				load_entry(ENTRY_INDEX_W'(i), ENTRY_TIME_W'(t));
			end
		end
	endtask

	// Query times: mostly inside the first few loops, near frame edges or the limit
	function automatic logic [QUERY_TIME_W-1:0] pick_query_time();
		int unsigned r, last, loops, off, f;
		longint      v;
		r = $urandom_range(99);
		if (r < 8)
			return {1'b1, 31'($urandom)};
		if (r < 10)
			return '0;
		if (r < 12)
			return 32'h7FFF_FFFF;
		if (r < 30)
			return $urandom;
		last = 32'(shadow_times[cur_frames - 1]);
		if (cur_frames < 2 || last == 0)
			return $urandom_range(1, 1000);
		if (cur_limit != 0 && $urandom_range(3) == 0)
			loops = cur_limit - 1 + $urandom_range(1);
		else
			loops = $urandom_range(0, 3);
		f = $urandom_range(0, cur_frames - 1);
		r = $urandom_range(3);
		if (r == 0)
			off = 32'(shadow_times[f]);
		else if (r == 1)
			off = 32'(shadow_times[f]) - 1;
		else
			off = $urandom_range(0, last - 1);
		v = longint'(loops) * last + (off % last);
		if (v > 64'h7FFF_FFFF)
			v = 64'h7FFF_FFFF;
		return v[QUERY_TIME_W-1:0];
	endfunction

	initial begin
		int unsigned n, mc, burst, r;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single frame after reset, then a time below zero
		query_at(32'd5);
		query_at(32'hFFFF_FFFF);

		// four frames up to the top of the time range, three loops allowed
		set_config(4, 3);
		load_entry(8'd0, 24'd0);
		load_entry(8'd1, 24'd10);
		load_entry(8'd2, 24'hFF_FFFE);
		load_entry(8'd3, 24'hFF_FFFF);
		query_at(32'd0);
		query_at(32'h8000_0000);
		query_at(32'h7FFF_FFFF);          // past the loop limit
		query_at(32'd5);                  // halfway between frames 0 and 1
		query_at(32'd16777215);           // start of the second loop
		query_at(32'd33554440);           // third loop, inside frame 1
		query_at(32'd50331645);           // exactly at the limit

		// last frame time zero
		load_entry(8'd3, 24'd0);
		query_at(32'd7);

		// table out of order: frame 0 above frame 1
		load_entry(8'd0, 24'd30);
		load_entry(8'd1, 24'd10);
		load_entry(8'd3, 24'd50);
		query_at(32'd5);
		query_at(32'd40);

		// unlimited looping with a one-tick period: largest loop count
		set_config(2, 0);
		load_entry(8'd0, 24'd0);
		load_entry(8'd1, 24'd1);
		query_at(32'h7FFF_FFFF);

		// random phases, each with its own settings and table
		phases_run = 0;
		while (loads_sent + queries_sent < ITEM_TARGET) begin
			case (phases_run)
				0: begin n = TABLE_DEPTH; mc = 16'hFFFF; end
				1: begin n = 2; mc = 1; end
				2: begin n = 1; mc = 0; end
				3: begin n = $urandom_range(2, 12); mc = 0; end
				default: begin
					r = $urandom_range(99);
					if (r < 5)       n = 1;
					else if (r < 60) n = $urandom_range(2, 16);
					else if (r < 85) n = $urandom_range(17, 64);
					else if (r < 95) n = $urandom_range(65, 255);
					else             n = TABLE_DEPTH;
					r = $urandom_range(99);
					if (r < 20)      mc = 0;
					else if (r < 40) mc = $urandom_range(1, 3);
					else if (r < 55) mc = 16'hFFFF;
					else if (r < 75) mc = $urandom_range(4, 20);
					else             mc = $urandom_range(0, 16'hFFFF);
				end
			endcase
			set_config(n, mc);
			// one long phase runs both sides at full rate
			gaps_on <= (phases_run != 3);
			fill_table(n);
			burst = (phases_run == 3) ? 400 : $urandom_range(30, 90);
			repeat (burst) begin
				if ($urandom_range(99) < 8)
					load_entry(ENTRY_INDEX_W'($urandom), ENTRY_TIME_W'($urandom));
				else
					query_at(pick_query_time());
			end
			phases_run++;
		end

		drain_and_hold();
		$display("Sent %0d table loads and %0d lookups over %0d register settings,",
			loads_sent, queries_sent, phases_run + 3);
		$display("frame counts 1 to 256, loop limits 0 to 65535; %0d results compared.",
			checked);
		if (fail_count == 0 && waiting == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ktl_pkg.sv
rtl/ktl_ctrl.sv
rtl/ktl_dp.sv
rtl/keyframe_time_lookup_core.sv
verif/ktl_lookup_checker.sv
verif/tb_keyframe_time_lookup_core.sv
